// ----- design/fixed_block_pool_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator assertion macros
// concurrent property wrappers used by the checker file fbpa_checker.sv
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FBPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define FBPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- design/fbpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fbpa_pkg
// types and constants of the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int IDX_W   = 10;
    localparam int ID_W    = 8;
    localparam int CNT_W   = 11;
    localparam int ADDR_W  = 32;
    localparam int BYTES_W = 17;

    localparam logic [CNT_W-1:0] MIN_TOTAL = 11'd2;
    localparam int               CNT_MAX   = 2047;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [1:0] REG_BLOCK_BYTES = 2'd1;
    localparam logic [1:0] REG_BLOCK_TOTAL = 2'd2;

    typedef enum logic [2:0] {
        STS_GRANTED   = 3'd0,
        STS_EMPTY     = 3'd1,
        STS_QUEUED    = 3'd2,
        STS_RELEASED  = 3'd3,
        STS_HANDED    = 3'd4,
        STS_OVERFLOW  = 3'd5,
        STS_WAIT_FULL = 3'd6,
        STS_BAD_INDEX = 3'd7
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

// ----- design/fixed_block_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// equal-size block pool with a lifo free list and a fifo of waiting requesters
// ----------------------------------------------------------------------------
// usage
//   s_axis: request beats. tuser = {may_wait, op}; tdata = {block_index,
//   requester_id}. op 0 allocates, op 1 releases a block.
//   m_axis: one result beat per request. tuser = status; tdata = {free_blocks,
//   receiver_id, granted_address, granted_index}.
//   apb: pool_base at 0x0, block_bytes at 0x4, block_total at 0x8. any write
//   to these re-initializes the pool (all blocks free, no waiters).
// timing
//   a request beat is taken in the idle state, and the exec state updates the
//   pool and registers its result beat; no new beat is taken in the exec state. the
//   idle cycle that takes the beat also reads the free-list head from the
//   link store, and the following cycle updates and writes back.
//   a finished result waits in the output register; the next request is
//   still taken, but its update cycle holds until the output beat is taken.
// reset
//   synchronous, active low: registers return to their reset values and the
//   pool is empty of waiters with all blocks free. the link store and waiter
//   store need no clearing, so the block is ready right after reset.
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS  = 1024,
    parameter int MAX_WAITERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // requester_id, block_index, zero pad
    input  logic [1:0]  s_axis_tuser,   // op, may_wait
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // granted_index, granted_address,
                                        // receiver_id, free_blocks, zero pad
    output logic [2:0]  m_axis_tuser,   // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LAW = $clog2(MAX_BLOCKS);
    localparam int WHW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int WCW = $clog2(MAX_WAITERS + 1);
    localparam int SW  = WCW + 1;
    localparam int CAP = (MAX_BLOCKS < CNT_MAX) ? MAX_BLOCKS : CNT_MAX;
    localparam logic [CNT_W-1:0] CAP_TOTAL = CNT_W'(CAP);
    localparam logic [WCW-1:0]   WAIT_FULL = WCW'(MAX_WAITERS);
    localparam logic [WHW-1:0]   HEAD_LAST = WHW'(MAX_WAITERS - 1);
    localparam logic [SW-1:0]    WAIT_WRAP = SW'(MAX_WAITERS);

    logic [IDX_W-1:0] link_mem [MAX_BLOCKS];
    logic [ID_W-1:0]  wait_mem [MAX_WAITERS];

    t_state           r_state, n_state;
    logic [31:0]      r_pool_base;
    logic [16:0]      r_block_bytes;
    logic [10:0]      r_block_total;
    logic [IDX_W-1:0] r_stack_top, n_stack_top;
    logic [CNT_W-1:0] r_stack_count, n_stack_count;
    logic [CNT_W-1:0] r_fresh_next, n_fresh_next;
    logic [WHW-1:0]   r_wait_head, n_wait_head;
    logic [WCW-1:0]   r_wait_count, n_wait_count;

    logic             r_op, r_may_wait;
    logic [ID_W-1:0]  r_req;
    logic [IDX_W-1:0] r_bidx;
    logic [IDX_W-1:0] r_link_rd;
    logic [ID_W-1:0]  r_wait_rd;

    logic             r_out_valid, n_out_valid;
    t_status          r_status, n_status;
    logic [IDX_W-1:0] r_gidx, n_gidx;
    logic [31:0]      r_gaddr, n_gaddr;
    logic [ID_W-1:0]  r_rid, n_rid;
    logic [CNT_W-1:0] r_free, n_free;

    logic             w_in_beat, w_go, w_cfg_wr, w_cfg_init;
    logic             w_link_we, w_wait_we, w_has_blk;
    logic [CNT_W-1:0] w_total, w_tail_len, w_free_now, w_idx;
    logic [27:0]      w_prod;
    logic [31:0]      w_addr;
    logic [LAW+IDX_W-1:0] w_top_ext, w_bidx_ext;
    logic [SW-1:0]    w_tail_sum, w_tail_mod;
    logic [WHW-1:0]   w_tail;

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr      = psel && penable && pwrite && pready;
    assign w_cfg_init    = w_cfg_wr &&
                           (paddr[3:2] inside {REG_POOL_BASE, REG_BLOCK_BYTES, REG_BLOCK_TOTAL});

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {3'b000, r_free, r_rid, r_gaddr, r_gidx};

    always_comb begin
        case (paddr[3:2])
            REG_POOL_BASE:   prdata = r_pool_base;
            REG_BLOCK_BYTES: prdata = {15'd0, r_block_bytes};
            REG_BLOCK_TOTAL: prdata = {21'd0, r_block_total};
            default:         prdata = 32'd0;
        endcase
    end

    // effective pool size and current free count
    assign w_total    = (r_block_total < MIN_TOTAL) ? MIN_TOTAL :
                        ((r_block_total > CAP_TOTAL) ? CAP_TOTAL : r_block_total);
    assign w_tail_len = (r_fresh_next < w_total) ? (w_total - r_fresh_next) : '0;
    assign w_free_now = r_stack_count + w_tail_len;

    assign w_top_ext  = {{LAW{1'b0}}, r_stack_top};
    assign w_bidx_ext = {{LAW{1'b0}}, r_bidx};

    assign w_tail_sum = SW'(r_wait_head) + SW'(r_wait_count);
    assign w_tail_mod = (w_tail_sum >= WAIT_WRAP) ? (w_tail_sum - WAIT_WRAP) : w_tail_sum;
    assign w_tail     = w_tail_mod[WHW-1:0];

    assign w_go = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);

    assign w_prod = 28'(r_block_bytes) * 28'(w_idx);
    assign w_addr = r_pool_base + 32'(w_prod);

    always_comb begin
        n_state       = r_state;
        n_stack_top   = r_stack_top;
        n_stack_count = r_stack_count;
        n_fresh_next  = r_fresh_next;
        n_wait_head   = r_wait_head;
        n_wait_count  = r_wait_count;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_status      = STS_EMPTY;
        n_rid         = '0;
        n_free        = w_free_now;
        w_idx         = '0;
        w_has_blk     = 1'b0;
        w_link_we     = 1'b0;
        w_wait_we     = 1'b0;

        if (r_op == OP_ALLOC) begin
            if (w_free_now != '0) begin
                w_has_blk = 1'b1;
                n_status  = STS_GRANTED;
                n_rid     = r_req;
                n_free    = w_free_now - 1'b1;
                if (r_stack_count != '0) begin
                    w_idx         = CNT_W'(r_stack_top);
                    n_stack_top   = r_link_rd;
                    n_stack_count = r_stack_count - 1'b1;
                end else begin
                    w_idx        = r_fresh_next;
                    n_fresh_next = r_fresh_next + 1'b1;
                end
            end else if (!r_may_wait) begin
                n_status = STS_EMPTY;
            end else if (r_wait_count == WAIT_FULL) begin
                n_status = STS_WAIT_FULL;
            end else begin
                n_status     = STS_QUEUED;
                w_wait_we    = 1'b1;
                n_wait_count = r_wait_count + 1'b1;
            end
        end else begin
            if (CNT_W'(r_bidx) >= w_total) begin
                n_status = STS_BAD_INDEX;
            end else if (r_wait_count != '0) begin
                n_status     = STS_HANDED;
                w_has_blk    = 1'b1;
                w_idx        = CNT_W'(r_bidx);
                n_rid        = r_wait_rd;
                n_wait_head  = (r_wait_head == HEAD_LAST) ? '0 : (r_wait_head + 1'b1);
                n_wait_count = r_wait_count - 1'b1;
            end else if (w_free_now < w_total) begin
                n_status      = STS_RELEASED;
                w_link_we     = 1'b1;
                n_stack_top   = r_bidx;
                n_stack_count = r_stack_count + 1'b1;
                n_free        = w_free_now + 1'b1;
            end else begin
                n_status = STS_OVERFLOW;
            end
        end

        n_gidx  = w_has_blk ? w_idx[IDX_W-1:0] : '0;
        n_gaddr = w_has_blk ? w_addr : '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_go) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base   <= 32'd0;
            r_block_bytes <= 17'd4;
            r_block_total <= 11'd1024;
            r_stack_top   <= '0;
            r_stack_count <= '0;
            r_fresh_next  <= '0;
            r_wait_head   <= '0;
            r_wait_count  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_go) begin
                r_stack_top   <= n_stack_top;
                r_stack_count <= n_stack_count;
                r_fresh_next  <= n_fresh_next;
                r_wait_head   <= n_wait_head;
                r_wait_count  <= n_wait_count;
            end
            if (w_cfg_wr) begin
                case (paddr[3:2])
                    REG_POOL_BASE:   r_pool_base   <= pwdata;
                    REG_BLOCK_BYTES: r_block_bytes <= pwdata[16:0];
                    REG_BLOCK_TOTAL: r_block_total <= pwdata[10:0];
                    default: ;
                endcase
            end
            if (w_cfg_init) begin
                r_stack_top   <= '0;
                r_stack_count <= '0;
                r_fresh_next  <= '0;
                r_wait_head   <= '0;
                r_wait_count  <= '0;
            end
        end
    end

    // request capture and result register
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_op       <= s_axis_tuser[0];
            r_may_wait <= s_axis_tuser[1];
            r_req      <= s_axis_tdata[7:0];
            r_bidx     <= s_axis_tdata[17:8];
        end
        if (w_go) begin
            r_status <= n_status;
            r_gidx   <= n_gidx;
            r_gaddr  <= n_gaddr;
            r_rid    <= n_rid;
            r_free   <= n_free;
        end
    end

    // link store: read head link every cycle, push writes the old head
    always_ff @(posedge i_clk) begin
        r_link_rd <= link_mem[w_top_ext[LAW-1:0]];
        if (w_go && w_link_we) begin
            link_mem[w_bidx_ext[LAW-1:0]] <= r_stack_top;
        end
    end

    // waiter store: read oldest waiter every cycle, queue writes at the tail
    always_ff @(posedge i_clk) begin
        r_wait_rd <= wait_mem[r_wait_head];
        if (w_go && w_wait_we) begin
            wait_mem[w_tail] <= r_req;
        end
    end

endmodule

// ----- design/fbpa_checker.sv -----
// ----------------------------------------------------------------------------
// fbpa_checker
// port-level checks of the fixed block pool allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_assert.svh"

module fbpa_checker
    import fbpa_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    logic w_in_beat, w_no_blk;

    assign w_in_beat = s_axis_tvalid && s_axis_tready;
    assign w_no_blk  = m_axis_tvalid && ((m_axis_tuser == STS_EMPTY) ||
                       (m_axis_tuser == STS_QUEUED) || (m_axis_tuser == STS_WAIT_FULL));

    `FBPA_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, w_in_beat, !s_axis_tready)

    `FBPA_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, w_in_beat, ##1 m_axis_tvalid)

    `FBPA_ASSERT_IMP(a_empty_pool, i_clk, i_rst_n, w_no_blk,
        (m_axis_tdata[60:50] == 11'd0) && (m_axis_tdata[41:10] == 32'd0))

    `FBPA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
